@@ src/mct_pkg.sv @@
// Package for the multiplexed countdown timers block.
// Holds payload structs, cell command and token types, and codes.
// No dependencies.
package mct_pkg;

   localparam int NUM_TIMERS_DEF = 32;
   localparam int TIME_BITS_DEF = 32;
   localparam int IDX_MAX_W = 6;
   localparam logic [30:0] MAX_TICKS = 31'h7FFF_FFFF;

   localparam logic [1:0] REQ_DECLARE = 2'd0;
   localparam logic [1:0] REQ_CANCEL = 2'd1;
   localparam logic [1:0] REQ_EXPIRE = 2'd2;
   localparam logic [1:0] REQ_SPARE = 2'd3;

   localparam logic [2:0] ST_DECLARED = 3'd0;
   localparam logic [2:0] ST_FULL = 3'd1;
   localparam logic [2:0] ST_CANCELLED = 3'd2;
   localparam logic [2:0] ST_UNUSED = 3'd3;
   localparam logic [2:0] ST_EXPIRY = 3'd4;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [30:0] duration;
      logic [4:0]  slot;
      logic [31:0] now;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [4:0]  given_slot;
      logic [31:0] expired_mask;
      logic        start_timer;
      logic [30:0] timer_load;
      logic        next_valid;
   } rsp_payload_type;

   typedef struct packed {
      logic                 valid;
      logic                 found_free;
      logic [IDX_MAX_W-1:0] free_idx;
      logic                 found;
      logic [IDX_MAX_W-1:0] best_idx;
      logic [30:0]          best_val;
   } tok_type;

   typedef struct packed {
      logic                 clear_fired;
      logic                 age_en;
      logic [31:0]          elapsed;
      logic                 kill_en;
      logic [IDX_MAX_W-1:0] kill_idx;
      logic                 wr_en;
      logic [IDX_MAX_W-1:0] wr_idx;
      logic [30:0]          wr_val;
   } cmd_type;

endpackage

@@ src/mct_cell.sv @@
// One timer slot of the chain: active flag, remaining ticks, fired flag.
// Ages itself when the sweep token passes and hands the token on.
// Depends on mct_pkg.
module mct_cell #(
   parameter int IDX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  mct_pkg::cmd_type cmd,
   input  mct_pkg::tok_type tok_in,
   output mct_pkg::tok_type tok_out,
   output logic             active,
   output logic             fired
);

   localparam logic [mct_pkg::IDX_MAX_W-1:0] IDX_CODE = mct_pkg::IDX_MAX_W'(IDX);

   logic             active_ff, active_in;
   logic             fired_ff, fired_in;
   logic [30:0]      rem_ff, rem_in;
   mct_pkg::tok_type tok_ff, tok_in_nx;
   logic [30:0]      aged;

   assign aged = rem_ff - cmd.elapsed[30:0];

   always_comb begin
      active_in = active_ff;
      rem_in = rem_ff;
      fired_in = fired_ff & ~cmd.clear_fired;
      tok_in_nx = tok_in;
      if (tok_in.valid) begin
         if (!active_ff && !tok_in.found_free) begin
            tok_in_nx.found_free = 1'b1;
            tok_in_nx.free_idx = IDX_CODE;
         end
         if (active_ff && cmd.age_en) begin
            if ({1'b0, rem_ff} > cmd.elapsed) begin
               rem_in = aged;
               if (!tok_in.found || aged < tok_in.best_val) begin
                  tok_in_nx.found = 1'b1;
                  tok_in_nx.best_idx = IDX_CODE;
                  tok_in_nx.best_val = aged;
               end
            end else begin
               active_in = 1'b0;
               fired_in = 1'b1;
            end
         end
      end
      if (cmd.kill_en && cmd.kill_idx == IDX_CODE) begin
         active_in = 1'b0;
      end
      if (cmd.wr_en && cmd.wr_idx == IDX_CODE) begin
         active_in = 1'b1;
         rem_in = cmd.wr_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         fired_ff <= 1'b0;
         tok_ff <= '0;
      end else begin
         active_ff <= active_in;
         fired_ff <= fired_in;
         tok_ff <= tok_in_nx;
      end
      rem_ff <= rem_in;
   end

   assign tok_out = tok_ff;
   assign active = active_ff;
   assign fired = fired_ff;

endmodule

@@ src/multiplexed_countdown_timers_core.sv @@
// Top level of the multiplexed countdown timers block: request decode,
// sweep control and result register over a chain of mct_cell slots.
// Depends on mct_pkg and mct_cell.
//
// Each request is accepted, then the sweep token is injected and passes the chain
// of slot cells (one slot per cycle, where each slot offers itself as free and, on
// an aging request, ages, fires or offers itself as the new minimum); the token is
// captured at the end of the chain, and then the outcome is committed. The commit
// waits while an earlier result is still stalled on the response channel. A new
// request is taken once the previous one has committed, even while its result
// still waits on the response channel.
module multiplexed_countdown_timers_core #(
   parameter int NUM_TIMERS = mct_pkg::NUM_TIMERS_DEF,
   parameter int TIME_BITS = mct_pkg::TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  mct_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output mct_pkg::rsp_payload_type rsp_data
);

   localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int MASK_N = (NUM_TIMERS < 32) ? NUM_TIMERS : 32;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SWEEP  = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   typedef enum logic [2:0] {
      OP_DECL_EMPTY,
      OP_DECL_AGE,
      OP_DECL_SLOW,
      OP_FULL,
      OP_CAN_BAD,
      OP_CAN_AGE,
      OP_CAN_PLAIN,
      OP_EXPIRE
   } op_type;

   state_type                state_ff, state_in;
   op_type                   op_ff, op_in;
   logic                     age_ff;
   logic [31:0]              elapsed_ff;
   logic [30:0]              dur_ff, sat_ff, sat_in;
   logic [TIME_BITS-1:0]     now_ff, now_t, restart_ff, restart_in;
   logic                     inject_ff;
   mct_pkg::tok_type         fin_ff;
   logic                     have_ff, have_in;
   logic [IDX_W-1:0]         next_ff, next_in;
   logic [30:0]              next_rem_ff, next_rem_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   mct_pkg::rsp_payload_type rsp_ff, rsp_in;

   mct_pkg::tok_type         tok [NUM_TIMERS+1];
   logic [NUM_TIMERS-1:0]    active_vec, fired_vec;
   logic [31:0]              mask;
   mct_pkg::cmd_type         cmd;

   logic                     accept, commit, full, slot_live, is_next;
   logic [31:0]              elapsed;
   logic [32:0]              sum;

   assign req_ready = (state_ff == S_IDLE);
   assign accept = req_valid && req_ready;
   assign commit = (state_ff == S_FINISH) && (!rsp_valid_ff || rsp_ready);

   assign now_t = req_data.now[TIME_BITS-1:0];
   assign elapsed = 32'(now_t - restart_ff);
   assign sum = 33'(req_data.duration) + 33'(elapsed);
   assign full = &active_vec;
   assign is_next = have_ff && (7'(next_ff) == 7'(req_data.slot));

   always_comb begin
      slot_live = 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
         if (7'(req_data.slot) == 7'(i) && active_vec[i]) begin
            slot_live = 1'b1;
         end
      end
   end

   always_comb begin
      if (sum > 33'(mct_pkg::MAX_TICKS)) begin
         sat_in = mct_pkg::MAX_TICKS;
      end else begin
         sat_in = sum[30:0];
      end
      case (req_data.req_type)
         mct_pkg::REQ_DECLARE: begin
            if (full) op_in = OP_FULL;
            else if (!have_ff) op_in = OP_DECL_EMPTY;
            else if (sum < 33'(next_rem_ff)) op_in = OP_DECL_AGE;
            else op_in = OP_DECL_SLOW;
         end
         mct_pkg::REQ_CANCEL: begin
            if (!slot_live) op_in = OP_CAN_BAD;
            else if (is_next) op_in = OP_CAN_AGE;
            else op_in = OP_CAN_PLAIN;
         end
         default: op_in = OP_EXPIRE;
      endcase
   end

   assign tok[0] = '{valid: inject_ff, default: '0};

   genvar g;
   generate
      for (g = 0; g < NUM_TIMERS; g++) begin : g_cell
         mct_cell #(.IDX(g)) u_cell (
            .clock   (clock),
            .reset   (reset),
            .cmd     (cmd),
            .tok_in  (tok[g]),
            .tok_out (tok[g+1]),
            .active  (active_vec[g]),
            .fired   (fired_vec[g])
         );
      end
      for (g = 0; g < 32; g++) begin : g_mask
         if (g < MASK_N) begin : g_on
            assign mask[g] = fired_vec[g];
         end else begin : g_off
            assign mask[g] = 1'b0;
         end
      end
   endgenerate

   always_comb begin
      cmd.clear_fired = accept;
      cmd.age_en = age_ff;
      cmd.elapsed = elapsed_ff;
      cmd.kill_en = accept && (op_in == OP_CAN_AGE || op_in == OP_CAN_PLAIN);
      cmd.kill_idx = mct_pkg::IDX_MAX_W'(req_data.slot);
      cmd.wr_en = commit
         && (op_ff == OP_DECL_EMPTY || op_ff == OP_DECL_AGE || op_ff == OP_DECL_SLOW);
      cmd.wr_idx = fin_ff.free_idx;
      cmd.wr_val = (op_ff == OP_DECL_SLOW) ? sat_ff : dur_ff;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_SWEEP;
         S_SWEEP: if (tok[NUM_TIMERS].valid) state_in = S_FINISH;
         S_FINISH: if (commit) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      have_in = have_ff;
      next_in = next_ff;
      next_rem_in = next_rem_ff;
      restart_in = restart_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (commit) begin
         rsp_valid_in = 1'b1;
         rsp_in = '0;
         rsp_in.expired_mask = mask;
         case (op_ff) inside
            OP_DECL_EMPTY, OP_DECL_AGE: begin
               rsp_in.status = mct_pkg::ST_DECLARED;
               rsp_in.given_slot = fin_ff.free_idx[4:0];
               have_in = 1'b1;
               next_in = fin_ff.free_idx[IDX_W-1:0];
               next_rem_in = dur_ff;
               restart_in = now_ff;
               rsp_in.start_timer = 1'b1;
               rsp_in.timer_load = dur_ff;
            end
            OP_DECL_SLOW: begin
               rsp_in.status = mct_pkg::ST_DECLARED;
               rsp_in.given_slot = fin_ff.free_idx[4:0];
            end
            OP_FULL: rsp_in.status = mct_pkg::ST_FULL;
            OP_CAN_BAD: rsp_in.status = mct_pkg::ST_UNUSED;
            OP_CAN_PLAIN: rsp_in.status = mct_pkg::ST_CANCELLED;
            default: begin
               rsp_in.status = (op_ff == OP_CAN_AGE) ? mct_pkg::ST_CANCELLED
                                                     : mct_pkg::ST_EXPIRY;
               have_in = fin_ff.found;
               next_in = fin_ff.found ? fin_ff.best_idx[IDX_W-1:0] : '0;
               next_rem_in = fin_ff.best_val;
               if (fin_ff.found) begin
                  restart_in = now_ff;
                  rsp_in.start_timer = 1'b1;
                  rsp_in.timer_load = fin_ff.best_val;
               end
            end
         endcase
         rsp_in.next_valid = have_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         inject_ff <= 1'b0;
         age_ff <= 1'b0;
         have_ff <= 1'b0;
         next_ff <= '0;
         restart_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         inject_ff <= accept;
         if (accept) begin
            age_ff <= (op_in == OP_DECL_AGE || op_in == OP_CAN_AGE || op_in == OP_EXPIRE);
         end
         have_ff <= have_in;
         next_ff <= next_in;
         restart_ff <= restart_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         op_ff <= op_in;
         elapsed_ff <= elapsed;
         dur_ff <= req_data.duration;
         sat_ff <= sat_in;
         now_ff <= now_t;
      end
      if (state_ff == S_SWEEP && tok[NUM_TIMERS].valid) begin
         fin_ff <= tok[NUM_TIMERS];
      end
      next_rem_ff <= next_rem_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

endmodule

@@ src/mct_checker.sv @@
// Port-level checks for multiplexed_countdown_timers_core, with its bind.
// Depends on mct_pkg.
module mct_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input mct_pkg::rsp_payload_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_start_next: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.start_timer |-> rsp_data.next_valid)
      else $error("restart without a pending timer");

   a_full_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == mct_pkg::ST_FULL
                    || rsp_data.status == mct_pkg::ST_UNUSED)
      |-> rsp_data.expired_mask == '0 && !rsp_data.start_timer)
      else $error("rejected transaction changed timers");

endmodule

bind multiplexed_countdown_timers_core mct_checker u_mct_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ verif/tb_multiplexed_countdown_timers_core.sv @@
// Testbench for multiplexed_countdown_timers_core: drives declare, cancel and
// expiry transactions and checks every response against a behavioral timer table.
// Depends on mct_pkg and the multiplexed_countdown_timers_core RTL.
class timer_table_scoreboard;
   bit          active[32];
   bit [30:0]   remaining[32];
   bit [31:0]   restart_at;
   bit [4:0]    next_slot;
   bit          have_next;
   mct_pkg::rsp_payload_type pending[$];
   int          mismatches;

   function void clear();
      for (int i = 0; i < 32; i++) begin
         active[i] = 0;
         remaining[i] = '0;
      end
      restart_at = '0;
      next_slot = '0;
      have_next = 0;
      pending.delete();
      mismatches = 0;
   endfunction

   function bit [31:0] age_slots(bit [31:0] elapsed);
      bit [31:0] fired;
      bit        found;
      int        best;
      fired = '0;
      found = 0;
      best = 0;
      for (int i = 0; i < 32; i++) begin
         if (active[i]) begin
            if ({1'b0, remaining[i]} > elapsed) begin
               remaining[i] = remaining[i] - elapsed[30:0];
               if (!found || remaining[i] < remaining[best]) begin
                  best = i;
                  found = 1;
               end
            end else begin
               active[i] = 0;
               fired[i] = 1'b1;
            end
         end
      end
      have_next = found;
      next_slot = found ? best[4:0] : '0;
      return fired;
   endfunction

   function void note_request(mct_pkg::req_payload_type rq);
      mct_pkg::rsp_payload_type r;
      bit [31:0] elapsed;
      bit [32:0] sum;
      int        free_idx;
      r = '0;
      elapsed = rq.now - restart_at;
      if (rq.req_type == mct_pkg::REQ_DECLARE) begin
         free_idx = -1;
         for (int i = 31; i >= 0; i--)
            if (!active[i]) free_idx = i;
         if (free_idx < 0) begin
            r.status = mct_pkg::ST_FULL;
         end else begin
            r.status = mct_pkg::ST_DECLARED;
            r.given_slot = free_idx[4:0];
            sum = {2'b0, rq.duration} + {1'b0, elapsed};
            if (!have_next || sum < {2'b0, remaining[next_slot]}) begin
               if (have_next) r.expired_mask = age_slots(elapsed);
               remaining[free_idx] = rq.duration;
               restart_at = rq.now;
               next_slot = free_idx[4:0];
               have_next = 1;
               r.start_timer = 1;
               r.timer_load = rq.duration;
            end else begin
               remaining[free_idx] = (sum > {2'b0, mct_pkg::MAX_TICKS}) ?
                                     mct_pkg::MAX_TICKS : sum[30:0];
            end
            active[free_idx] = 1;
         end
      end else if (rq.req_type == mct_pkg::REQ_CANCEL) begin
         if (!active[rq.slot]) begin
            r.status = mct_pkg::ST_UNUSED;
         end else begin
            r.status = mct_pkg::ST_CANCELLED;
            active[rq.slot] = 0;
            if (have_next && next_slot == rq.slot) begin
               r.expired_mask = age_slots(elapsed);
               if (have_next) begin
                  restart_at = rq.now;
                  r.start_timer = 1;
                  r.timer_load = remaining[next_slot];
               end
            end
         end
      end else begin
         r.status = mct_pkg::ST_EXPIRY;
         r.expired_mask = age_slots(elapsed);
         if (have_next) begin
            restart_at = rq.now;
            r.start_timer = 1;
            r.timer_load = remaining[next_slot];
         end
      end
      r.next_valid = have_next;
      pending.push_back(r);
   endfunction

   function void check_response(mct_pkg::rsp_payload_type got);
      mct_pkg::rsp_payload_type exp;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected response %h", got);
         return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status || got.given_slot !== exp.given_slot ||
          got.expired_mask !== exp.expired_mask ||
          got.start_timer !== exp.start_timer ||
          got.timer_load !== exp.timer_load ||
          got.next_valid !== exp.next_valid) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected %h actual %h", exp, got);
      end
   endfunction
endclass

module tb_multiplexed_countdown_timers_core;

   logic                     clock = 0;
   logic                     reset = 1;
   logic                     req_valid = 0;
   logic                     req_ready;
   mct_pkg::req_payload_type req_data = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 0;
   mct_pkg::rsp_payload_type rsp_data;

   timer_table_scoreboard timers = new();
   longint unsigned cycle_count = 0;
   bit [31:0] clock_now = 0;

   multiplexed_countdown_timers_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 2000000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) timers.note_request(req_data);
      if (!reset && rsp_valid && rsp_ready) timers.check_response(rsp_data);
   end

   initial begin
      int wait_cycles;
      @(negedge clock);
      while (1) begin
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
         if (wait_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   task automatic send(input logic [1:0] kind, input logic [30:0] dur,
                       input logic [4:0] slot_sel, input logic [31:0] step);
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      clock_now = clock_now + step;
      req_data <= '{req_type: kind, duration: dur, slot: slot_sel, now: clock_now};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(negedge clock);
      while (timers.pending.size() != 0) @(negedge clock);
   endtask

   function automatic logic [30:0] pick_duration();
      case ($urandom_range(0, 4))
         0: return 31'($urandom_range(0, 20));
         1: return 31'($urandom_range(0, 2000));
         2: return mct_pkg::MAX_TICKS - 31'($urandom_range(0, 5));
         3: return 31'($urandom());
         default: return 31'($urandom_range(0, 300));
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0: return 32'd0;
         1: return $urandom();
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(0, 200);
      endcase
   endfunction

   initial begin
      int kind;
      timers.clear();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send(mct_pkg::REQ_DECLARE, 31'd0, 5'd0, 32'd0);
      send(mct_pkg::REQ_EXPIRE, 31'd0, 5'd0, 32'd0);
      send(mct_pkg::REQ_EXPIRE, 31'd0, 5'd0, 32'd5);
      send(mct_pkg::REQ_CANCEL, 31'd0, 5'd31, 32'd1);
      send(mct_pkg::REQ_DECLARE, mct_pkg::MAX_TICKS, 5'd0, 32'hFFFF_FFFF);
      send(mct_pkg::REQ_DECLARE, mct_pkg::MAX_TICKS, 5'd0, 32'h7FFF_FFFF);
      send(mct_pkg::REQ_DECLARE, 31'd10, 5'd0, 32'd1);
      send(mct_pkg::REQ_CANCEL, 31'd0, 5'd2, 32'd1);
      send(mct_pkg::REQ_CANCEL, 31'd0, 5'd0, 32'd3);
      send(mct_pkg::REQ_SPARE, 31'd0, 5'd0, 32'd3);
      for (int i = 0; i < 33; i++)
         send(mct_pkg::REQ_DECLARE, 31'(1000 + i), 5'd0, 32'd0);
      send(mct_pkg::REQ_CANCEL, 31'd0, 5'd0, 32'd1);
      send(mct_pkg::REQ_EXPIRE, 31'd0, 5'd0, 32'd2000);
      drain();

      for (int n = 0; n < 2000; n++) begin
         kind = $urandom_range(0, 9);
         if (kind < 5)
            send(mct_pkg::REQ_DECLARE, pick_duration(), 5'($urandom()), pick_step());
         else if (kind < 8)
            send(mct_pkg::REQ_CANCEL, pick_duration(), 5'($urandom()), pick_step());
         else
            send(2'($urandom_range(2, 3)), pick_duration(), 5'($urandom()), pick_step());
         if (n == 1000) drain();
      end

      drain();
      repeat (100) @(negedge clock);
      if (timers.mismatches == 0 && timers.pending.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end
endmodule
